// ----- sv/lsp_pkg.sv -----
// shared types and constants for the lidar scan packet parser
`default_nettype none

package lsp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W = 3;
	localparam int unsigned ANGLE_W = 9;
	localparam int unsigned DIST_W = 14;
	localparam int unsigned QUAL_W = 6;
	localparam int unsigned ANGLE_LOW_W = 7;
	localparam int unsigned BINS_W = 10;

	// index of a byte inside one five-byte packet
	localparam logic [POS_W-1:0] POS_QUALITY = 3'd0;
	localparam logic [POS_W-1:0] POS_ANGLE_LO = 3'd1;
	localparam logic [POS_W-1:0] POS_ANGLE_HI = 3'd2;
	localparam logic [POS_W-1:0] POS_DIST_LO = 3'd3;
	localparam logic [POS_W-1:0] POS_DIST_HI = 3'd4;

	typedef enum logic [1:0] {
		STATUS_POINT = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_CHECK = 2'd2
	} status_t;

	typedef struct packed {
		logic hit;
		status_t status;
		logic [ANGLE_W-1:0] angle_deg;
		logic [DIST_W-1:0] distance_mm;
		logic [QUAL_W-1:0] quality;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/lsp_parser.sv -----
// packet framing state and field decode for one received byte
`default_nettype none

module lsp_parser #(
	parameter int unsigned ANGLE_BINS = 360
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic [lsp_pkg::BYTE_W-1:0] rx_byte,
	output lsp_pkg::result_t result
);

	localparam logic [lsp_pkg::BINS_W-1:0] BINS = lsp_pkg::BINS_W'(ANGLE_BINS);

	logic in_packet_q;
	logic [lsp_pkg::POS_W-1:0] byte_position_q;
	logic [lsp_pkg::QUAL_W-1:0] held_quality_q;
	logic [lsp_pkg::ANGLE_LOW_W-1:0] angle_low_bits_q;
	logic [lsp_pkg::ANGLE_W-1:0] angle_bin_q;
	logic [lsp_pkg::BYTE_W-1:0] distance_low_byte_q;

	logic start;
	logic active;
	logic [lsp_pkg::POS_W-1:0] pos;
	logic in_packet_d;
	logic [lsp_pkg::POS_W-1:0] byte_position_d;
	logic ld_quality;
	logic ld_angle_lo;
	logic ld_angle_hi;
	logic ld_dist_lo;

	// a start byte has its two low bits different
	assign start = !in_packet_q && (rx_byte[0] ^ rx_byte[1]);
	assign active = in_packet_q || start;
	assign pos = in_packet_q ? byte_position_q : lsp_pkg::POS_QUALITY;

	always_comb begin
		result = '0;
		result.status = lsp_pkg::STATUS_POINT;
		in_packet_d = in_packet_q;
		byte_position_d = byte_position_q;
		ld_quality = 1'b0;
		ld_angle_lo = 1'b0;
		ld_angle_hi = 1'b0;
		ld_dist_lo = 1'b0;
		if (active) begin
			in_packet_d = 1'b1;
			byte_position_d = pos + lsp_pkg::POS_W'(1);
			case (pos)
				lsp_pkg::POS_QUALITY: begin
					ld_quality = 1'b1;
				end
				lsp_pkg::POS_ANGLE_LO: begin
					if (!rx_byte[0]) begin
						// check bit clear: report and hunt again
						result.hit = 1'b1;
						result.status = lsp_pkg::STATUS_CHECK;
						in_packet_d = 1'b0;
						byte_position_d = lsp_pkg::POS_QUALITY;
					end else begin
						ld_angle_lo = 1'b1;
					end
				end
				lsp_pkg::POS_ANGLE_HI: begin
					ld_angle_hi = 1'b1;
				end
				lsp_pkg::POS_DIST_LO: begin
					ld_dist_lo = 1'b1;
				end
				lsp_pkg::POS_DIST_HI: begin
					result.hit = 1'b1;
					result.status = ({1'b0, angle_bin_q} >= BINS) ?
						lsp_pkg::STATUS_RANGE : lsp_pkg::STATUS_POINT;
					result.angle_deg = angle_bin_q;
					// q2 millimetres to whole millimetres
					result.distance_mm = {rx_byte, distance_low_byte_q[7:2]};
					result.quality = held_quality_q;
					in_packet_d = 1'b0;
					byte_position_d = lsp_pkg::POS_QUALITY;
				end
				default: begin
					in_packet_d = 1'b0;
					byte_position_d = lsp_pkg::POS_QUALITY;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			byte_position_q <= lsp_pkg::POS_QUALITY;
			held_quality_q <= '0;
			angle_low_bits_q <= '0;
			angle_bin_q <= '0;
			distance_low_byte_q <= '0;
		end else if (step) begin
			in_packet_q <= in_packet_d;
			byte_position_q <= byte_position_d;
			if (ld_quality) begin
				held_quality_q <= rx_byte[7:2];
			end
			if (ld_angle_lo) begin
				angle_low_bits_q <= rx_byte[7:1];
			end
			if (ld_angle_hi) begin
				// q6 angle divided by 64
				angle_bin_q <= {rx_byte, angle_low_bits_q[6]};
			end
			if (ld_dist_lo) begin
				distance_low_byte_q <= rx_byte;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/lidar_scan_packet_parser.sv -----
// Parses five-byte scan packets from a rangefinder byte stream, one byte per
// transaction. A byte is registered on acceptance, decoded from that register
// and any result lands in an output register, so the block takes one byte
// every cycle while the result side is not stalled. Each packet gives
// exactly one result: a point, an angle at or above ANGLE_BINS, or a check
// bit failure, after which the parser hunts for the next start byte.
`default_nettype none

module lidar_scan_packet_parser #(
	parameter int unsigned ANGLE_BINS = 360
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rx_valid,
	output logic rx_stall,
	input wire logic [lsp_pkg::BYTE_W-1:0] rx_byte,
	output logic res_valid,
	input wire logic res_stall,
	output logic [1:0] status,
	output logic [lsp_pkg::ANGLE_W-1:0] angle_deg,
	output logic [lsp_pkg::DIST_W-1:0] distance_mm,
	output logic [lsp_pkg::QUAL_W-1:0] quality
);

	logic valid_s1;
	logic [lsp_pkg::BYTE_W-1:0] rx_byte_s1;
	logic res_valid_q;
	lsp_pkg::result_t res_q;
	lsp_pkg::result_t result;
	logic out_blocked;
	logic step;

	assign out_blocked = res_valid_q && res_stall;
	assign step = valid_s1 && !out_blocked;
	assign rx_stall = valid_s1 && out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	lsp_parser #(
		.ANGLE_BINS(ANGLE_BINS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.rx_byte(rx_byte_s1),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && result.hit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.hit) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign status = res_q.status;
	assign angle_deg = res_q.angle_deg;
	assign distance_mm = res_q.distance_mm;
	assign quality = res_q.quality;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// testbench for the lidar scan packet parser: byte stream in, parsed packet results out
module tb_top;

	localparam int unsigned ANGLE_BINS = 360;
	localparam int unsigned HOLD_CYCLES = 120;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PRINT_CAP = 30;

	typedef struct {
		lsp_pkg::status_t status;
		logic [lsp_pkg::ANGLE_W-1:0] angle_deg;
		logic [lsp_pkg::DIST_W-1:0] distance_mm;
		logic [lsp_pkg::QUAL_W-1:0] quality;
	} scan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic [lsp_pkg::BYTE_W-1:0] rx_byte = '0;
	logic res_stall = 1'b0;
	logic rx_stall;
	logic res_valid;
	logic [1:0] status;
	logic [lsp_pkg::ANGLE_W-1:0] angle_deg;
	logic [lsp_pkg::DIST_W-1:0] distance_mm;
	logic [lsp_pkg::QUAL_W-1:0] quality;

	lidar_scan_packet_parser #(
		.ANGLE_BINS(ANGLE_BINS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.angle_deg(angle_deg),
		.distance_mm(distance_mm),
		.quality(quality)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// parser state as the byte stream has left it
	bit in_packet;
	logic [lsp_pkg::POS_W-1:0] next_pos;
	logic [lsp_pkg::QUAL_W-1:0] kept_quality;
	logic [lsp_pkg::ANGLE_LOW_W-1:0] kept_angle_low;
	logic [lsp_pkg::ANGLE_W-1:0] kept_angle_deg;
	logic [lsp_pkg::BYTE_W-1:0] kept_dist_low;

	scan_result_t awaited[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned hunt_drops = 0;
	int unsigned status_count[3] = '{0, 0, 0};
	int unsigned idle_pct = 26;
	int unsigned hold_asked = 0;
	int unsigned hold_given = 0;
	int unsigned hold_left = 0;

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatches < PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
				got, want);
		mismatches++;
	endtask

	task automatic push_result(input lsp_pkg::status_t st,
			input logic [lsp_pkg::ANGLE_W-1:0] ang,
			input logic [lsp_pkg::DIST_W-1:0] dist_mm,
			input logic [lsp_pkg::QUAL_W-1:0] q);
		scan_result_t r;
		r.status = st;
		r.angle_deg = ang;
		r.distance_mm = dist_mm;
		r.quality = q;
		awaited.push_back(r);
		status_count[st]++;
	endtask

	// advance the parser state by one accepted byte
	task automatic decode_rx_byte(input logic [lsp_pkg::BYTE_W-1:0] b);
		logic [14:0] angle_q6;
		logic [15:0] dist_q2;
		if (!in_packet) begin
			// start byte needs bit 0 and bit 1 to differ
			if (b[0] == b[1]) begin
				hunt_drops++;
				return;
			end
			in_packet = 1'b1;
			next_pos = lsp_pkg::POS_QUALITY;
		end
		case (next_pos)
			lsp_pkg::POS_QUALITY: kept_quality = b[7:2];
			lsp_pkg::POS_ANGLE_LO: begin
				if (!b[0]) begin
					in_packet = 1'b0;
					next_pos = lsp_pkg::POS_QUALITY;
					push_result(lsp_pkg::STATUS_CHECK, '0, '0, '0);
					return;
				end
				kept_angle_low = b[7:1];
			end
			lsp_pkg::POS_ANGLE_HI: begin
				angle_q6 = {b, kept_angle_low};
				kept_angle_deg = angle_q6[14:6];
			end
			lsp_pkg::POS_DIST_LO: kept_dist_low = b;
			lsp_pkg::POS_DIST_HI: begin
				dist_q2 = {b, kept_dist_low};
				in_packet = 1'b0;
				next_pos = lsp_pkg::POS_QUALITY;
				push_result((kept_angle_deg >= ANGLE_BINS) ? lsp_pkg::STATUS_RANGE :
					lsp_pkg::STATUS_POINT, kept_angle_deg, dist_q2[15:2], kept_quality);
				return;
			end
			default: begin
				in_packet = 1'b0;
				next_pos = lsp_pkg::POS_QUALITY;
				return;
			end
		endcase
		next_pos = next_pos + 1'b1;
	endtask

	// offer one byte and hold it until the parser takes it
	task automatic send_byte(input logic [lsp_pkg::BYTE_W-1:0] b);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (rx_stall);
		bytes_sent++;
		decode_rx_byte(b);
	endtask

	task automatic send_packet(input logic [lsp_pkg::QUAL_W-1:0] q, input bit chk,
			input logic [14:0] angle_q6, input logic [15:0] dist_q2);
		logic [1:0] flag;
		flag = $urandom_range(0, 1) ? 2'b01 : 2'b10;
		send_byte({q, flag});
		send_byte({angle_q6[6:0], chk});
		if (!chk)
			return;
		send_byte(angle_q6[14:7]);
		send_byte(dist_q2[7:0]);
		send_byte(dist_q2[15:8]);
	endtask

	function automatic logic [14:0] pick_angle();
		case ($urandom_range(0, 3))
			0, 1: return 15'($urandom_range(0, ANGLE_BINS * 64 - 1));
			2: return 15'($urandom_range((ANGLE_BINS - 1) * 64, ANGLE_BINS * 64 + 63));
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	task automatic send_random_packet();
		send_packet(6'($urandom_range(0, 63)), $urandom_range(0, 9) != 0, pick_angle(),
			16'($urandom_range(0, 65535)));
	endtask

	task automatic wait_drained();
		rx_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited.size() != 0);
	endtask

	task automatic test_directed_packets();
		send_byte(8'h00);
		send_byte(8'hff);
		// all fields at their top, angle far past the bin count
		send_packet(6'h3f, 1'b1, 15'h7fff, 16'hffff);
		send_packet(6'h00, 1'b1, 15'h0000, 16'h0000);
		// check bit clear, then a start byte right after it
		send_packet(6'h15, 1'b0, 15'h7fff, 16'h0000);
		// last bin and the first angle past it
		send_packet(6'h2a, 1'b1, 15'((ANGLE_BINS - 1) * 64), 16'h1234);
		send_packet(6'h01, 1'b1, 15'(ANGLE_BINS * 64), 16'h0003);
		wait_drained();
	endtask

	task automatic test_random_stream(input int unsigned count);
		int unsigned stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 99) < 80)
				send_random_packet();
			else
				// stray bytes may open a packet mid-stream and shift the framing
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
		end
		wait_drained();
	endtask

	task automatic test_back_to_back(input int unsigned count);
		int unsigned stop_at;
		idle_pct = 0;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at)
			send_random_packet();
		wait_drained();
		idle_pct = 26;
	endtask

	task automatic test_output_hold();
		hold_asked <= hold_asked + 1;
		repeat (40) send_random_packet();
		// sender waits for every result before going on
		wait_drained();
		repeat (10) send_random_packet();
		wait_drained();
	endtask

	// result side: random stalls plus long holds on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_given) begin
			res_stall <= 1'b1;
			hold_given <= hold_given + 1;
			hold_left <= HOLD_CYCLES - 1;
		end else begin
			res_stall <= $urandom_range(0, 99) < idle_pct;
		end
	end

	always @(posedge clk) begin : check_results
		scan_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited.size() == 0) begin
				flag_mismatch("result with nothing pending, status", status, 0);
			end else begin
				want = awaited.pop_front();
				if (status !== want.status)
					flag_mismatch("status", status, want.status);
				if (angle_deg !== want.angle_deg)
					flag_mismatch("angle_deg", angle_deg, want.angle_deg);
				if (distance_mm !== want.distance_mm)
					flag_mismatch("distance_mm", distance_mm, want.distance_mm);
				if (quality !== want.quality)
					flag_mismatch("quality", quality, want.quality);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		in_packet = 1'b0;
		next_pos = lsp_pkg::POS_QUALITY;
		kept_quality = '0;
		kept_angle_low = '0;
		kept_angle_deg = '0;
		kept_dist_low = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_packets();
		test_random_stream(850);
		test_back_to_back(150);
		test_output_hold();
		test_random_stream(50);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d bytes: %0d points, %0d angles out of range, %0d check bit errors",
			bytes_sent, status_count[lsp_pkg::STATUS_POINT],
			status_count[lsp_pkg::STATUS_RANGE], status_count[lsp_pkg::STATUS_CHECK]);
		$display("%0d bytes dropped while hunting, %0d long output holds of %0d cycles",
			hunt_drops, hold_given, HOLD_CYCLES);
		if (mismatches == 0 && awaited.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/lsp_pkg.sv
sv/lsp_parser.sv
sv/lidar_scan_packet_parser.sv
bench/tb_top.sv
